// File: sv/sacl_pkg.sv
// Shared types and constants for the set-associative tag cache.
// Used by every module of the block except sacl_ram; no dependencies.
package sacl_pkg;

  localparam int unsigned SETS    = 256;
  localparam int unsigned WAYS    = 8;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TAG_W   = 30;
  localparam int unsigned RANK_W  = 3;
  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned WAY_W   = $clog2(WAYS);
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ROW_W   = WAYS * (TAG_W + RANK_W + 1);

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam logic [1:0] REG_OFFSET_W = 2'd0;
  localparam logic [1:0] REG_SET_W    = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;
  localparam logic [1:0] REG_POLICY   = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       way_used;
    logic [7:0]       set_used;
    logic             evicted;
    logic [TAG_W-1:0] evicted_tag;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] load_total;
    logic [CNT_W-1:0] store_total;
  } out_item_t;

  typedef struct packed {
    logic take;    // input transfer this cycle
    logic lookup;  // set row is on the RAM read port
  } dp_cmd_t;

endpackage

// File: sv/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/sacl_ctrl.sv
// Sequencer: idle, set lookup/update, result hold.
// Depends on sacl_pkg.
module sacl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sacl_pkg::dp_cmd_t cmd
);
  import sacl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign cmd.take   = (state_r == ST_IDLE) && in_valid;
  assign cmd.lookup = (state_r == ST_LOOK);
endmodule

// File: sv/sacl_dp.sv
// Datapath: config registers, set RAM, hit/replacement logic, counters, result.
// Depends on sacl_pkg and sacl_ram.
module sacl_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_wdata,
  input  sacl_pkg::dp_cmd_t   cmd,
  input  sacl_pkg::in_item_t  in_data,
  output sacl_pkg::out_item_t out_data
);
  import sacl_pkg::*;

  logic [3:0] off_w_r, set_w_r, ways_r;
  logic       fifo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_w_r <= 4'd2;
      set_w_r <= 4'd0;
      ways_r  <= 4'd1;
      fifo_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_W: off_w_r <= cfg_wdata;
        REG_SET_W:    set_w_r <= cfg_wdata;
        REG_WAYS:     ways_r  <= cfg_wdata;
        REG_POLICY:   fifo_r  <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // clamped configuration
  logic [3:0] ob, ib, ways;
  always_comb begin
    ob = off_w_r;
    if (ob < 4'd2)  ob = 4'd2;
    if (ob > 4'd12) ob = 4'd12;
    ib = (set_w_r > 4'd8) ? 4'd8 : set_w_r;
    ways = ways_r;
    if (ways == 4'd0) ways = 4'd1;
    if (ways > 4'(WAYS)) ways = 4'(WAYS);
  end

  logic [ADDR_W-1:0] sh_set, sh_tag;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_W:0]    set_mask;
  always_comb begin
    sh_set   = in_data.address >> ob;
    sh_tag   = in_data.address >> (5'(ob) + 5'(ib));
    set_mask = (9'd1 << ib) - 9'd1;
    set_in   = sh_set[SET_W-1:0] & set_mask[SET_W-1:0];
    tag_in   = sh_tag[TAG_W-1:0];
  end

  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             op_r;
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      set_r <= set_in;
      tag_r <= tag_in;
      op_r  <= in_data.operation;
    end
  end

  // row layout per way: {valid, rank, tag}
  logic [ROW_W-1:0] rd_row, wr_row;
  sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (cmd.lookup),
    .waddr (set_r),
    .wdata (wr_row),
    .raddr (set_in),
    .rdata (rd_row)
  );

  // rows never written read as empty
  logic [SETS-1:0] row_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) row_ok_r <= '0;
    else if (cmd.lookup) row_ok_r[set_r] <= 1'b1;
  end

  logic [WAYS-1:0]   v_old, srch;
  logic [RANK_W-1:0] rk_old [WAYS];
  logic [TAG_W-1:0]  tg_old [WAYS];
  logic [WAYS-1:0]   v_new;
  logic [RANK_W-1:0] rk_new [WAYS];
  logic [TAG_W-1:0]  tg_new [WAYS];
  logic              hit, empty_found, evict;
  logic [WAY_W-1:0]  hit_way, empty_way, best, way;
  logic [RANK_W:0]   old_rank;
  logic              touch;

  always_comb begin
    hit = 1'b0; hit_way = '0;
    empty_found = 1'b0; empty_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      v_old[i]  = row_ok_r[set_r] & rd_row[i*(TAG_W+RANK_W+1) + TAG_W + RANK_W];
      rk_old[i] = row_ok_r[set_r] ?
                  rd_row[i*(TAG_W+RANK_W+1) + TAG_W +: RANK_W] : '0;
      tg_old[i] = rd_row[i*(TAG_W+RANK_W+1) +: TAG_W];
      srch[i]   = 4'(i) < ways;
      if (!hit && srch[i] && v_old[i] && tg_old[i] == tag_r) begin
        hit = 1'b1; hit_way = WAY_W'(i);
      end
      if (!empty_found && srch[i] && !v_old[i]) begin
        empty_found = 1'b1; empty_way = WAY_W'(i);
      end
    end
    best = '0;
    for (int i = 1; i < WAYS; i++)
      if (srch[i] && rk_old[i] > rk_old[best]) best = WAY_W'(i);

    evict = !hit && !empty_found;
    if (hit)              way = hit_way;
    else if (empty_found) way = empty_way;
    else                  way = best;
    old_rank = empty_found && !hit ? {1'b1, {RANK_W{1'b0}}} : {1'b0, rk_old[way]};
    touch    = !(hit && fifo_r);

    for (int i = 0; i < WAYS; i++) begin
      v_new[i]  = v_old[i];
      rk_new[i] = rk_old[i];
      tg_new[i] = tg_old[i];
      if (touch && srch[i] && WAY_W'(i) != way && v_old[i] &&
          {1'b0, rk_old[i]} < old_rank && rk_old[i] < RANK_MAX)
        rk_new[i] = rk_old[i] + 1'b1;
      if (WAY_W'(i) == way) begin
        if (touch) rk_new[i] = '0;
        if (!hit) begin
          v_new[i]  = 1'b1;
          tg_new[i] = tag_r;
        end
      end
      wr_row[i*(TAG_W+RANK_W+1) +: TAG_W+RANK_W+1] = {v_new[i], rk_new[i], tg_new[i]};
    end
  end

  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r, load_cnt_r, store_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt, load_cnt_nxt, store_cnt_nxt;
  assign hit_cnt_nxt   = hit_cnt_r   + CNT_W'(hit);
  assign miss_cnt_nxt  = miss_cnt_r  + CNT_W'(!hit);
  assign load_cnt_nxt  = load_cnt_r  + CNT_W'(op_r == OP_LOAD);
  assign store_cnt_nxt = store_cnt_r + CNT_W'(op_r == OP_STORE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r <= '0; miss_cnt_r <= '0; load_cnt_r <= '0; store_cnt_r <= '0;
    end else if (cmd.lookup) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      load_cnt_r  <= load_cnt_nxt;
      store_cnt_r <= store_cnt_nxt;
    end
  end

  out_item_t res_r;
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      res_r.hit         <= hit;
      res_r.way_used    <= 3'(way);
      res_r.set_used    <= 8'(set_r);
      res_r.evicted     <= evict;
      res_r.evicted_tag <= evict ? tg_old[best] : '0;
      res_r.hit_total   <= hit_cnt_nxt;
      res_r.miss_total  <= miss_cnt_nxt;
      res_r.load_total  <= load_cnt_nxt;
      res_r.store_total <= store_cnt_nxt;
    end
  end
  assign out_data = res_r;
endmodule

// File: sv/set_assoc_cache_lru_fifo.sv
// Top level of the set-associative tag cache with LRU/FIFO replacement.
// Depends on sacl_pkg, sacl_ctrl, sacl_dp (and sacl_ram through sacl_dp).
//
//  port group   direction  handshake              payload
//  in_*         input      in_valid / in_stall    in_item_t  (operation, address)
//  out_*        output     out_valid / out_stall  out_item_t (hit .. store_total)
//  cfg_*        input      cfg_we                 cfg_index, cfg_wdata
//
// Each access goes through accept, set row read from the single-port-pair RAM
// then written back with counters, and result held until out_stall is low.
// One access in flight; in_stall is high from accept until the result transfers.
// Synchronous active-low reset clears counters and per-set valid flags and restores
// the config defaults; no clearing pass is needed.
module set_assoc_cache_lru_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sacl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sacl_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_wdata
);
  import sacl_pkg::*;

  dp_cmd_t cmd;

  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sacl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data)
  );

  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit_total + out_data.miss_total ==
                   out_data.load_total + out_data.store_total))
    else $error("hit+miss totals disagree with load+store totals");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.evicted)
    else $error("eviction reported on a hit");

  a_evtag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |-> out_data.evicted_tag == '0)
    else $error("evicted_tag nonzero without eviction");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> in_stall && !out_valid)
    else $error("accept did not block the input");
endmodule

// File: tb/tb.sv
// Testbench for set_assoc_cache_lru_fifo: random and directed loads/stores
// checked against a tag-cache model with LRU/FIFO ranks. Depends on sacl_pkg.
module tb;
  import sacl_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_OFFSET_W;
  logic [3:0] cfg_wdata = '0;

  int unsigned err_cnt = 0;
  int unsigned cyc = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  set_assoc_cache_lru_fifo i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0s: got %0h expected %0h", what, got, want);
    err_cnt++;
  endtask

  class cache_scoreboard;
    bit          valid_q[SETS][WAYS];
    logic [31:0] tag_q[SETS][WAYS];
    int unsigned rank_q[SETS][WAYS];
    logic [31:0] hits, misses, loads, stores;
    logic [3:0]  offset_w, set_w, ways_n;
    bit          fifo_mode;
    out_item_t   exp_q[$];

    function void clear();
      foreach (valid_q[s, w]) begin
        valid_q[s][w] = 0;
        tag_q[s][w] = '0;
        rank_q[s][w] = 0;
      end
      hits = 0; misses = 0; loads = 0; stores = 0;
      offset_w = 4'd2; set_w = 4'd0; ways_n = 4'd1; fifo_mode = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        REG_OFFSET_W: offset_w = val;
        REG_SET_W:    set_w = val;
        REG_WAYS:     ways_n = val;
        REG_POLICY:   fifo_mode = val[0];
        default: ;
      endcase
    endfunction

    function void touch(int unsigned s, int unsigned nw, int unsigned w, int unsigned old);
      for (int unsigned i = 0; i < nw; i++)
        if (i != w && valid_q[s][i] && rank_q[s][i] < old && rank_q[s][i] < 7)
          rank_q[s][i]++;
      rank_q[s][w] = 0;
    endfunction

    function void note_access(in_item_t it);
      int unsigned ob, ib, nw, s, w, best;
      logic [31:0] tg;
      out_item_t r;
      bit found;
      r = '0;
      ob = offset_w < 2 ? 2 : (offset_w > 12 ? 12 : offset_w);
      ib = set_w > 8 ? 8 : set_w;
      nw = ways_n < 1 ? 1 : (ways_n > WAYS ? WAYS : ways_n);
      if (it.operation == OP_STORE) stores++; else loads++;
      tg = it.address >> (ob + ib);
      s = (it.address >> ob) & ((32'd1 << ib) - 1);
      found = 0;
      for (int unsigned i = 0; i < nw && !found; i++)
        if (valid_q[s][i] && tag_q[s][i] == tg) begin
          found = 1; w = i;
        end
      if (found) begin
        hits++;
        r.hit = 1'b1;
        if (!fifo_mode) touch(s, nw, w, rank_q[s][w]);
      end else begin
        misses++;
        for (int unsigned i = 0; i < nw && !found; i++)
          if (!valid_q[s][i]) begin
            found = 1; w = i;
          end
        if (found) begin
          valid_q[s][w] = 1;
          tag_q[s][w] = tg;
          touch(s, nw, w, 8);
        end else begin
          best = 0;
          for (int unsigned i = 1; i < nw; i++)
            if (rank_q[s][i] > rank_q[s][best]) best = i;
          w = best;
          r.evicted = 1'b1;
          r.evicted_tag = tag_q[s][w][TAG_W-1:0];
          tag_q[s][w] = tg;
          touch(s, nw, w, rank_q[s][w]);
        end
      end
      r.way_used = w[2:0];
      r.set_used = s[7:0];
      r.hit_total = hits; r.miss_total = misses;
      r.load_total = loads; r.store_total = stores;
      exp_q.insert(exp_q.size(), r);
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (exp_q.size() == 0) begin
        report("unexpected result", 32'd0, 32'd0);
        return;
      end
      e = exp_q[0];
      exp_q.delete(0);
      if (got.hit != e.hit) report("hit", 32'(got.hit), 32'(e.hit));
      if (got.way_used != e.way_used)
        report("way_used", 32'(got.way_used), 32'(e.way_used));
      if (got.set_used != e.set_used)
        report("set_used", 32'(got.set_used), 32'(e.set_used));
      if (got.evicted != e.evicted) report("evicted", 32'(got.evicted), 32'(e.evicted));
      if (got.evicted_tag != e.evicted_tag)
        report("evicted_tag", 32'(got.evicted_tag), 32'(e.evicted_tag));
      if (got.hit_total != e.hit_total) report("hit_total", got.hit_total, e.hit_total);
      if (got.miss_total != e.miss_total) report("miss_total", got.miss_total, e.miss_total);
      if (got.load_total != e.load_total) report("load_total", got.load_total, e.load_total);
      if (got.store_total != e.store_total)
        report("store_total", got.store_total, e.store_total);
    endtask
  endclass

  cache_scoreboard sb = new();

  // result side: sample at rising edge, stall changes at falling edge
  always @(posedge clk) begin
    cyc++;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cyc > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // in_valid stays high between back-to-back items; it drops only on idle or drain
  task automatic send_access(input logic op, input logic [31:0] addr);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, address: addr};
    do @(posedge clk); while (in_stall);
    sb.note_access(in_data);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(input logic [3:0] ob, input logic [3:0] ib,
                           input logic [3:0] nw, input logic pol);
    drain();
    set_reg(REG_OFFSET_W, ob);
    set_reg(REG_SET_W, ib);
    set_reg(REG_WAYS, nw);
    set_reg(REG_POLICY, pol);
    cfg_we <= 1'b0;
  endtask

  // addresses drawn from a small tag pool so sets fill up and evict
  task automatic random_phase(input int n);
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) a = $urandom();
      else a = ($urandom_range(11) << 14) | ($urandom_range(3) << 6) | $urandom_range(63)
               | ($urandom_range(1) << 31);
      send_access(1'($urandom_range(1)), a);
    end
  endtask

  initial begin
    sb.clear();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset config, address extremes, both ops
    send_access(OP_LOAD, 32'h0);
    send_access(OP_STORE, 32'h0);
    send_access(OP_LOAD, 32'hFFFF_FFFF);
    send_access(OP_STORE, 32'h8000_0003);
    send_access(OP_LOAD, 32'h0000_0004);
    // out-of-range widths saturate; ways 0 acts as 1, 15 as 8
    configure(4'd0, 4'd15, 4'd0, 1'b0);
    send_access(OP_LOAD, 32'hFFFF_FFFF);
    send_access(OP_LOAD, 32'h0000_0100);
    configure(4'd15, 4'd8, 4'd15, 1'b1);
    for (int k = 0; k < 10; k++) send_access(k[0], 32'(32'h0010_0000 * k));
    send_access(OP_LOAD, 32'h0);
    configure(4'd12, 4'd8, 4'd8, 1'b0);
    for (int k = 0; k < 10; k++) send_access(OP_LOAD, 32'(32'h0010_0000 * (k % 9)));
    // reconfigure without flush: shrink ways
    configure(4'd12, 4'd8, 4'd2, 1'b0);
    send_access(OP_LOAD, 32'h0070_0000);

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      configure(ph == 0 ? 4'd2 : 4'($urandom_range(2, 12)), 4'($urandom_range(0, 8)),
                4'($urandom_range(1, 8)), 1'($urandom_range(1)));
      random_phase(100);
      if (ph == 5) drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (10) @(negedge clk);
    if (err_cnt == 0 && sb.exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
